>>> rtl/s128_pkg.sv
`default_nettype none
package s128_pkg;

    localparam int MagW = 128;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_CMP = 4'd4,
        OP_AND = 4'd5,
        OP_XOR = 4'd6,
        OP_SHL = 4'd7,
        OP_SHR = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    // result fields handed from the core to the output stage
    typedef struct packed {
        logic [127:0] res;
        logic         res_neg;
        logic         res_ovf;
        logic         res_nan;
        logic [127:0] rem;
        logic         rem_neg;
        logic [1:0]   cmp;
    } result_t;

    // cmp outcome codes
    localparam logic [1:0] CMP_LT = 2'b11;
    localparam logic [1:0] CMP_EQ = 2'b00;
    localparam logic [1:0] CMP_GT = 2'b01;

endpackage
`default_nettype wire

>>> rtl/s128_step.sv
`default_nettype none
// Shared add/subtract/compare unit: one 129-bit add or subtract per cycle, used for
// each restoring-divide step and each shift-add multiply step.
module s128_step
    import s128_pkg::*;
(
    input  wire logic [128:0] x,
    input  wire logic [127:0] y,
    input  wire logic         sub,
    output logic      [128:0] sum,
    output logic              ge
);
    logic [129:0] t;

    always_comb
    begin
        if (sub)
            t = {1'b0, x} - {2'b00, y};
        else
            t = {1'b0, x} + {2'b00, y};
        sum = t[128:0];
        ge  = ~t[129];
    end
endmodule
`default_nettype wire

>>> rtl/signed_128_arith_unit.sv
`default_nettype none
// Channel | dir | tdata fields (low bit first)
// s_axis  | in  | req_type[3:0] a_hi a_lo a_neg a_ovf a_nan b_hi b_lo b_neg b_ovf
//         |     | b_nan shift_amount[7:0]
// m_axis  | out | res_hi res_lo res_neg res_ovf res_nan rem_hi rem_lo rem_neg cmp[1:0]
// A full divide runs 128 steps of the shared subtractor and a full multiply
// 128 shift-add steps on the same unit; other operations are settled at accept.
// Reset clears the sequencer and output valid. s_axis_tready is high only in
// idle; a stalled result holds the next one in the done state until taken.
module signed_128_arith_unit
    import s128_pkg::*;
#(
    parameter int MAX_BITS = 128
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // req_type, a_hi, a_lo, a_neg, a_overflow, a_nan, b_hi, b_lo, b_neg,
    // b_overflow, b_nan, shift_amount, zero pad
    input  wire logic [279:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // res_hi, res_lo, res_neg, res_overflow, res_nan, rem_hi, rem_lo, rem_neg,
    // cmp_result, zero pad
    output logic      [263:0] m_axis_tdata
);
    // unpack request
    logic [3:0]   in_op;
    logic [127:0] in_a, in_b;
    logic         in_an, in_ao, in_aN, in_bn, in_bo, in_bN;
    logic [7:0]   in_sh;

    assign in_op = s_axis_tdata[3:0];
    assign in_a  = {s_axis_tdata[67:4], s_axis_tdata[131:68]};
    assign in_an = s_axis_tdata[132];
    assign in_ao = s_axis_tdata[133];
    assign in_aN = s_axis_tdata[134];
    assign in_b  = {s_axis_tdata[198:135], s_axis_tdata[262:199]};
    assign in_bn = s_axis_tdata[263];
    assign in_bo = s_axis_tdata[264];
    assign in_bN = s_axis_tdata[265];
    assign in_sh = s_axis_tdata[273:266];

    state_t state_reg, state_next;
    logic [128:0] acc_reg, acc_next;   // remainder / product
    logic [127:0] q_reg, q_next;       // dividend-quotient / multiplier
    logic [127:0] d_reg, d_next;       // divisor / multiplicand
    logic [6:0]   cnt_reg, cnt_next;
    result_t      out_reg, out_next;
    logic         div_reg, div_next;
    logic         vld_reg, vld_next;

    logic         accept;
    logic [128:0] su_x, su_sum;
    logic [127:0] su_y;
    logic         su_sub, su_ge;

    assign accept = s_axis_tvalid && s_axis_tready;

    s128_step u_step (
        .x   (su_x),
        .y   (su_y),
        .sub (su_sub),
        .sum (su_sum),
        .ge  (su_ge)
    );

    // bit length helpers for mul overflow test
    function automatic logic [7:0] blen(input logic [127:0] v);
        logic [7:0] n;
        n = 8'd0;
        for (int i = 0; i < 128; i++)
            if (v[i]) n = 8'(i + 1);
        return n;
    endfunction

    // magnitude compare and the ops settled at accept
    logic         a_lt_b;
    logic [128:0] addv;
    logic [127:0] shv;
    logic [8:0]   lensum;
    logic         mul_ovf;
    assign a_lt_b = in_a < in_b;
    assign lensum = {1'b0, blen(in_a)} + {1'b0, blen(in_b)};
    assign mul_ovf = ((|in_a[127:64]) && (|in_b[127:64])) || (lensum > 9'(MAX_BITS));

    // shared unit operand select
    always_comb
    begin
        su_sub = 1'b1;
        su_x   = {1'b0, in_a};
        su_y   = in_b;
        unique case (state_reg)
            ST_DIV:
            begin
                su_x   = {acc_reg[127:0], q_reg[127]};
                su_y   = d_reg;
                su_sub = 1'b1;
            end
            ST_MUL:
            begin
                su_x   = {acc_reg[127:0], 1'b0};
                su_y   = q_reg[127] ? d_reg : '0;
                su_sub = 1'b0;
            end
            default:
            begin
                su_sub = 1'b1;
                su_x   = {1'b0, in_a};
                su_y   = in_b;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = div_next ? ST_DIV :
                                 (in_op == OP_MUL && out_next.res_ovf == 1'b0 &&
                                  out_next.res_nan == 1'b0 && !mul_ovf) ? ST_MUL
                                 : ST_DONE;
            ST_DIV, ST_MUL:
                if (cnt_reg == 7'd127)
                    state_next = ST_DONE;
            ST_DONE:
                if (!vld_reg || m_axis_tready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        acc_next = acc_reg;
        q_next   = q_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        out_next = out_reg;
        div_next = 1'b0;
        addv     = {1'b0, in_a} + {1'b0, in_b};
        shv      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                out_next = '0;
                cnt_next = '0;
                acc_next = '0;
                q_next   = in_a;
                d_next   = in_b;
                if (in_op == OP_MUL)
                begin
                    q_next = in_b;
                    d_next = in_a;
                end
                unique case (in_op)
                    OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_XOR:
                    begin
                        out_next.res_neg = in_an;
                        out_next.res_ovf = in_ao | in_bo;
                        out_next.res_nan = in_aN | in_bN;
                        out_next.res     = in_a;
                        if (!(in_ao | in_bo | in_aN | in_bN))
                        begin
                            if (in_op == OP_ADD || in_op == OP_SUB)
                            begin
                                if ((in_op == OP_SUB ? ~in_bn : in_bn) == in_an)
                                begin
                                    out_next.res     = addv[127:0];
                                    out_next.res_ovf = addv[128];
                                end
                                else if (a_lt_b)
                                begin
                                    out_next.res     = in_b - in_a;
                                    out_next.res_neg = ~in_an;
                                end
                                else
                                    out_next.res = su_sum[127:0];
                            end
                            else if (in_op == OP_MUL)
                            begin
                                if (mul_ovf)
                                    out_next.res_ovf = 1'b1;
                                else
                                    out_next.res_neg = in_an ^ in_bn;
                            end
                            else if (in_op == OP_AND)
                                out_next.res = in_a & in_b;
                            else
                                out_next.res = in_a ^ in_b;
                        end
                    end
                    OP_DIV:
                    begin
                        if (in_ao | in_bo)
                            out_next.res_ovf = 1'b1;
                        else if (in_aN | in_bN || in_b == '0)
                            out_next.res_nan = 1'b1;
                        else
                        begin
                            out_next.res_neg = in_an ^ in_bn;
                            if (a_lt_b)
                            begin
                                out_next.rem     = in_a;
                                out_next.rem_neg = in_an;
                            end
                            else
                                div_next = 1'b1;
                        end
                    end
                    OP_CMP:
                    begin
                        if (in_ao | in_aN)
                            out_next.cmp = CMP_LT;
                        else if (in_bo | in_bN)
                            out_next.cmp = CMP_GT;
                        else if (in_an && !in_bn)
                            out_next.cmp = CMP_LT;
                        else if (!in_an && in_bn)
                            out_next.cmp = CMP_GT;
                        else if (in_a == in_b)
                            out_next.cmp = CMP_EQ;
                        else if (a_lt_b ^ in_an)
                            out_next.cmp = CMP_LT;
                        else
                            out_next.cmp = CMP_GT;
                    end
                    OP_SHL, OP_SHR:
                    begin
                        out_next.res_neg = in_an;
                        out_next.res_ovf = in_ao;
                        out_next.res_nan = in_aN;
                        if (in_sh[7])
                            shv = '0;
                        else if (in_op == OP_SHL)
                            shv = in_a << in_sh[6:0];
                        else
                            shv = in_a >> in_sh[6:0];
                        if ({1'b0, in_sh} > 9'(MAX_BITS))
                            out_next.res_neg = 1'b0;
                        else
                            out_next.res = shv;
                    end
                    default: out_next = '0;
                endcase
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 7'd1;
                q_next   = {q_reg[126:0], su_ge};
                acc_next = su_ge ? su_sum : su_x;
                if (cnt_reg == 7'd127)
                begin
                    out_next.res = {q_reg[126:0], su_ge};
                    out_next.rem = su_ge ? su_sum[127:0] : su_x[127:0];
                end
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + 7'd1;
                q_next   = {q_reg[126:0], 1'b0};
                acc_next = su_sum;
                if (cnt_reg == 7'd127)
                    out_next.res = su_sum[127:0];
            end
            default: ;
        endcase
    end

    // output valid
    always_comb
    begin
        vld_next = vld_reg;
        if (vld_reg && m_axis_tready)
            vld_next = 1'b0;
        if (state_reg == ST_DONE && (!vld_reg || m_axis_tready))
            vld_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vld_reg   <= 1'b0;
            cnt_reg   <= '0;
            div_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
            cnt_reg   <= cnt_next;
            div_reg   <= div_next & accept;
        end
    end

    // payload: working regs load in idle and update in compute; result copied at done
    result_t obuf_reg;
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        if (state_reg == ST_IDLE ? accept : 1'b1)
            out_reg <= out_next;
        if (state_reg == ST_DONE && (!vld_reg || m_axis_tready))
            obuf_reg <= out_reg;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata  = {2'b00, obuf_reg.cmp, obuf_reg.rem_neg,
                            obuf_reg.rem[63:0], obuf_reg.rem[127:64],
                            obuf_reg.res_nan, obuf_reg.res_ovf, obuf_reg.res_neg,
                            obuf_reg.res[63:0], obuf_reg.res[127:64]};

    // checks
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_MUL) |-> !s_axis_tready)
        else $error("ready while computing");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg != 7'd127) |=> state_reg == ST_DIV)
        else $error("divide ended early");
    a_cmp_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> obuf_reg.cmp != 2'b10)
        else $error("bad compare code");
    a_div_flag: assert property (@(posedge clk) disable iff (!rst_n)
        div_reg |-> state_reg == ST_DIV)
        else $error("divide start lost");

endmodule
`default_nettype wire
